>>> design/set_assoc_cache_lru_tracker_top_assert.svh
// Assertion macros for the LRU cache tracker.
`ifndef SET_ASSOC_CACHE_LRU_TRACKER_TOP_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_TRACKER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property checked at every clock edge outside reset.
`define SALRU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("salru assertion failed");
// Antecedent followed by a consequent in the next cycle.
`define SALRU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("salru assertion failed");
`else
`define SALRU_ASSERT(lbl, prop)
`define SALRU_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> design/salru_pkg.sv
// Shared types and constants for the LRU cache tracker.
`default_nettype none

package salru_pkg;

  localparam int MAX_SETS  = 256;
  localparam int MAX_WAYS  = 8;
  localparam int ADDR_BITS = 32;
  localparam int SET_W     = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int TAG_W     = 32;
  localparam int AGE_W     = 3;
  localparam int CNT_W     = 32;
  localparam int CMD_W     = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;
  localparam int SIB_W      = 4;
  localparam int WAYS_CFG_W = 4;
  localparam int BOB_W      = 5;

  localparam logic [AGE_W-1:0]      AGE_TOP       = '1;
  localparam logic [SIB_W-1:0]      SIB_RESET     = SIB_W'(4);
  localparam logic [WAYS_CFG_W-1:0] WAYS_RESET    = WAYS_CFG_W'(1);
  localparam logic [BOB_W-1:0]      BOB_RESET     = BOB_W'(4);

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_INDEX_BITS    = 2'd0,
    CFG_WAYS_IN_USE       = 2'd1,
    CFG_BLOCK_OFFSET_BITS = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE   = 1'b0,
    ST_UPDATE = 1'b1
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // latch the word and read its set row
    logic update;  // look up, write the row back, load the result
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> design/salru_ctrl.sv
// Controller state machine: sequences read and update of one word at a time.
`default_nettype none

module salru_ctrl (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire                    out_stall_i,
  output salru_pkg::ctrl_cmd_t   cmd_o
);
  import salru_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  // Result slot can take a new word when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
      end
      ST_UPDATE: begin
        cmd_o.update = out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
    out_valid_d = cmd_o.update || (out_valid_q && out_stall_i);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

>>> design/salru_dpath.sv
// Datapath: config registers, set row memory, LRU lookup and update, counters.
`default_nettype none

module salru_dpath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  salru_pkg::ctrl_cmd_t                  cmd_i,
  input  wire  [salru_pkg::CMD_W-1:0]           command_i,
  input  wire  [salru_pkg::ADDR_BITS-1:0]       address_i,
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [salru_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [salru_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                  first_hit_o,
  output logic                                  evicted_o,
  output logic [salru_pkg::CNT_W-1:0]           total_hits_o,
  output logic [salru_pkg::CNT_W-1:0]           total_misses_o,
  output logic [salru_pkg::CNT_W-1:0]           total_evictions_o
);
  import salru_pkg::*;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [1:0] inc);
    logic [CNT_W:0] sum;
    sum = {1'b0, c} + (CNT_W+1)'(inc);
    return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  // Configuration registers
  logic [SIB_W-1:0]      sib_q;
  logic [WAYS_CFG_W-1:0] ways_q;
  logic [BOB_W-1:0]      bob_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sib_q  <= SIB_RESET;
      ways_q <= WAYS_RESET;
      bob_q  <= BOB_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SET_INDEX_BITS:    sib_q  <= cfg_data_i[SIB_W-1:0];
        CFG_WAYS_IN_USE:       ways_q <= cfg_data_i[WAYS_CFG_W-1:0];
        CFG_BLOCK_OFFSET_BITS: bob_q  <= cfg_data_i[BOB_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split
  logic [SET_W-1:0]     set_mask;
  logic [ADDR_BITS-1:0] off_addr;
  logic [ADDR_BITS-1:0] tag_addr;
  logic [5:0]           tag_shift;
  logic [SET_W-1:0]     set_d;
  logic [TAG_W-1:0]     tag_d;

  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(sib_q));
    end
    off_addr  = address_i >> bob_q;
    tag_shift = {1'b0, bob_q} + {2'b0, sib_q};
    tag_addr  = address_i >> tag_shift;
    set_d     = off_addr[SET_W-1:0] & set_mask;
    tag_d     = tag_addr[TAG_W-1:0];
  end

  // Word registers
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic             modify_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      set_q    <= set_d;
      tag_q    <= tag_d;
      modify_q <= (command_i == CMD_MODIFY);
    end
  end

  // Set row memory; a row never written reads as all zero
  row_t              mem_q [MAX_SETS];
  row_t              rd_row_q;
  logic [MAX_SETS-1:0] row_valid_q;
  logic              rd_row_valid_q;
  row_t              row_wr;

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) mem_q[set_q] <= row_wr;
    if (cmd_i.load)   rd_row_q     <= mem_q[set_d];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q    <= '0;
      rd_row_valid_q <= 1'b0;
    end else begin
      if (cmd_i.update) row_valid_q[set_q] <= 1'b1;
      if (cmd_i.load)   rd_row_valid_q     <= row_valid_q[set_d];
    end
  end

  // Lookup, victim choice and age update
  row_t                  row;
  logic [WAYS_CFG_W-1:0] ways_eff;
  logic [MAX_WAYS-1:0]   in_use;
  logic                  hit;
  logic                  found_inv;
  logic [WAY_W-1:0]      hit_way;
  logic [WAY_W-1:0]      inv_way;
  logic [WAY_W-1:0]      victim;
  logic [WAY_W-1:0]      way_sel;
  logic [AGE_W-1:0]      rank;
  logic                  evict;

  always_comb begin
    row = rd_row_valid_q ? rd_row_q : '0;

    if (ways_q == '0) begin
      ways_eff = WAYS_CFG_W'(1);
    end else if (int'(ways_q) > MAX_WAYS) begin
      ways_eff = WAYS_CFG_W'(MAX_WAYS);
    end else begin
      ways_eff = ways_q;
    end

    hit       = 1'b0;
    found_inv = 1'b0;
    hit_way   = '0;
    inv_way   = '0;
    victim    = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      in_use[i] = (i < int'(ways_eff));
      if (!hit && in_use[i] && row[i].valid && row[i].tag == tag_q) begin
        hit     = 1'b1;
        hit_way = WAY_W'(i);
      end
      if (!found_inv && in_use[i] && !row[i].valid) begin
        found_inv = 1'b1;
        inv_way   = WAY_W'(i);
      end
    end
    for (int i = 1; i < MAX_WAYS; i++) begin
      if (in_use[i] && row[i].age > row[victim].age) victim = WAY_W'(i);
    end

    evict   = !hit && !found_inv;
    way_sel = hit ? hit_way : (found_inv ? inv_way : victim);
    rank    = hit ? row[hit_way].age : AGE_TOP;

    // Touch the selected way; younger ways in use age by one
    row_wr = row;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (in_use[i] && WAY_W'(i) != way_sel && row[i].age < rank &&
          row[i].age != AGE_TOP) begin
        row_wr[i].age = row[i].age + AGE_W'(1);
      end
    end
    row_wr[way_sel].age = '0;
    if (!hit) begin
      row_wr[way_sel].valid = 1'b1;
      row_wr[way_sel].tag   = tag_q;
    end
  end

  // Counters and result flags; a modify adds one hit for its store
  logic [CNT_W-1:0] hit_cnt_q, miss_cnt_q, evict_cnt_q;
  logic             first_hit_q, evicted_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else if (cmd_i.update) begin
      hit_cnt_q   <= sat_add(hit_cnt_q, {1'b0, hit} + {1'b0, modify_q});
      miss_cnt_q  <= sat_add(miss_cnt_q, {1'b0, !hit});
      evict_cnt_q <= sat_add(evict_cnt_q, {1'b0, evict});
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      first_hit_q <= hit;
      evicted_q   <= evict;
    end
  end

  assign first_hit_o       = first_hit_q;
  assign evicted_o         = evicted_q;
  assign total_hits_o      = hit_cnt_q;
  assign total_misses_o    = miss_cnt_q;
  assign total_evictions_o = evict_cnt_q;

endmodule

`default_nettype wire

>>> design/set_assoc_cache_lru_tracker_top.sv
// Set-associative cache tag tracker with true LRU: top level.
// Input channel (in_valid_i / in_stall_o) carries one access word: command_i
// (load, store or modify) and address_i. Output channel (out_valid_o /
// out_stall_i) returns one word per access: first_hit_o, evicted_o and the
// saturating running totals of hits, misses and evictions.
// Configuration: cfg_valid_i / cfg_ready_o write cfg_data_i to register
// cfg_index_i (0 set index bits, 1 ways in use, 2 block offset bits); other
// indexes are ignored. Write only while no access is in flight.
// Sequence: the accept cycle reads the set row from the row memory; the update
// state then compares tags, picks the way, writes the row back and loads the
// result once the output register is free. A new access is accepted only
// after the previous one has written its row, as the single row memory is
// read then written.
// Stall: a finished result waits in the output register while the next access
// is accepted and read; its update waits until the output register frees.
// Reset: all lines invalid, ages and counters zero, configuration at 4 set
// bits, 1 way, 4 offset bits; no clearing pass is needed.
`default_nettype none

module set_assoc_cache_lru_tracker_top (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire  [salru_pkg::CMD_W-1:0]        command_i,
  input  wire  [salru_pkg::ADDR_BITS-1:0]    address_i,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic                               first_hit_o,
  output logic                               evicted_o,
  output logic [salru_pkg::CNT_W-1:0]        total_hits_o,
  output logic [salru_pkg::CNT_W-1:0]        total_misses_o,
  output logic [salru_pkg::CNT_W-1:0]        total_evictions_o,
  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [salru_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [salru_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import salru_pkg::*;

  ctrl_cmd_t cmd;

  salru_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  salru_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .command_i         (command_i),
    .address_i         (address_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .first_hit_o       (first_hit_o),
    .evicted_o         (evicted_o),
    .total_hits_o      (total_hits_o),
    .total_misses_o    (total_misses_o),
    .total_evictions_o (total_evictions_o)
  );

`include "set_assoc_cache_lru_tracker_top_assert.svh"

  // A hit never replaces a line
  `SALRU_ASSERT(a_hit_no_evict, out_valid_o |-> !(first_hit_o && evicted_o))
  // Every eviction is also counted as a miss
  `SALRU_ASSERT(a_evict_le_miss, out_valid_o |-> (total_evictions_o <= total_misses_o))
  // An accepted access blocks the input during its update cycle
  `SALRU_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o)
  // A result appears when the update cycle completes
  `SALRU_ASSERT_NEXT(a_result_follows, cmd.update, out_valid_o)

endmodule

`default_nettype wire

>>> bench/salru_checker.sv
// Checker for the LRU cache tracker: predicts each access result and compares it.
`timescale 1ns / 1ps

module salru_checker (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  input  wire                                in_stall_i,
  input  wire [salru_pkg::CMD_W-1:0]         command_i,
  input  wire [salru_pkg::ADDR_BITS-1:0]     address_i,
  input  wire                                out_valid_i,
  input  wire                                out_stall_i,
  input  wire                                first_hit_i,
  input  wire                                evicted_i,
  input  wire [salru_pkg::CNT_W-1:0]         total_hits_i,
  input  wire [salru_pkg::CNT_W-1:0]         total_misses_i,
  input  wire [salru_pkg::CNT_W-1:0]         total_evictions_i,
  input  wire                                cfg_valid_i,
  input  wire                                cfg_ready_i,
  input  wire [salru_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [salru_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o
);
  import salru_pkg::*;

  typedef struct {
    logic             first_hit;
    logic             evicted;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } access_result_t;

  // Expected result words, oldest first
  access_result_t result_q[$];
  access_result_t want;
  int             fails = 0;

  // Shadow tag store
  logic             held_valid [MAX_SETS][MAX_WAYS];
  logic [TAG_W-1:0] held_tag   [MAX_SETS][MAX_WAYS];
  logic [AGE_W-1:0] held_rank  [MAX_SETS][MAX_WAYS];
  logic [CNT_W-1:0] hit_cnt, miss_cnt, evict_cnt;

  // Shadow configuration
  logic [SIB_W-1:0]      set_bits;
  logic [WAYS_CFG_W-1:0] way_cfg;
  logic [BOB_W-1:0]      offset_bits;

  function automatic int unsigned active_ways();
    if (way_cfg == 0) return 1;
    if (int'(way_cfg) > MAX_WAYS) return MAX_WAYS;
    return int'(way_cfg);
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  // Make way w most recent; ways younger than its old rank age by one
  function automatic void promote(int unsigned set, int unsigned w,
                                  logic [AGE_W-1:0] old_rank, int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i != w && held_rank[set][i] < old_rank && held_rank[set][i] != AGE_TOP)
        held_rank[set][i] = held_rank[set][i] + 1'b1;
    end
    held_rank[set][w] = '0;
  endfunction

  // One lookup with fill or LRU replacement; returns hit
  function automatic bit probe(int unsigned set, logic [TAG_W-1:0] tag, output bit replaced);
    int unsigned n;
    int unsigned victim;
    n = active_ways();
    replaced = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      if (held_valid[set][i] && held_tag[set][i] == tag) begin
        hit_cnt = bump(hit_cnt);
        promote(set, i, held_rank[set][i], n);
        return 1'b1;
      end
    end
    miss_cnt = bump(miss_cnt);
    for (int unsigned i = 0; i < n; i++) begin
      if (!held_valid[set][i]) begin
        held_valid[set][i] = 1'b1;
        held_tag[set][i] = tag;
        promote(set, i, AGE_TOP, n);
        return 1'b0;
      end
    end
    victim = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (held_rank[set][i] > held_rank[set][victim]) victim = i;
    end
    held_tag[set][victim] = tag;
    promote(set, victim, AGE_TOP, n);
    evict_cnt = bump(evict_cnt);
    replaced = 1'b1;
    return 1'b0;
  endfunction

  // Split the address, run the access (twice for a modify), snapshot counters
  function automatic access_result_t predict(logic [CMD_W-1:0] cmd,
                                             logic [ADDR_BITS-1:0] addr);
    logic [63:0]    wide;
    logic [63:0]    set_sel;
    int unsigned    shift_tag;
    int unsigned    set;
    logic [TAG_W-1:0] tag;
    bit             ev;
    bit             ev_second;
    access_result_t r;
    wide = 64'(addr);
    shift_tag = int'(offset_bits) + int'(set_bits);
    set_sel = (wide >> offset_bits) & ((64'd1 << set_bits) - 64'd1);
    tag = TAG_W'(wide >> shift_tag);
    set = int'(set_sel % MAX_SETS);
    r.first_hit = probe(set, tag, ev);
    r.evicted = ev;
    if (cmd == CMD_MODIFY) void'(probe(set, tag, ev_second));
    r.hits = hit_cnt;
    r.misses = miss_cnt;
    r.evictions = evict_cnt;
    return r;
  endfunction

  function automatic void check_field(string name, logic [CNT_W-1:0] want_v,
                                      logic [CNT_W-1:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      fails++;
    end
  endfunction

  // Watch all three channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAX_SETS; s++) begin
        for (int w = 0; w < MAX_WAYS; w++) begin
          held_valid[s][w] = 1'b0;
          held_tag[s][w] = '0;
          held_rank[s][w] = '0;
        end
      end
      hit_cnt = '0;
      miss_cnt = '0;
      evict_cnt = '0;
      set_bits = SIB_RESET;
      way_cfg = WAYS_RESET;
      offset_bits = BOB_RESET;
      result_q.delete();
      pending_o = 0;
      fail_count_o = fails;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("result word with no access outstanding");
          fails++;
        end else begin
          want = result_q.pop_front();
          check_field("first_hit", CNT_W'(want.first_hit), CNT_W'(first_hit_i));
          check_field("evicted", CNT_W'(want.evicted), CNT_W'(evicted_i));
          check_field("total_hits", want.hits, total_hits_i);
          check_field("total_misses", want.misses, total_misses_i);
          check_field("total_evictions", want.evictions, total_evictions_i);
        end
      end
      if (in_valid_i && !in_stall_i) result_q.push_back(predict(command_i, address_i));
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_SET_INDEX_BITS:    set_bits = cfg_data_i[SIB_W-1:0];
          CFG_WAYS_IN_USE:       way_cfg = cfg_data_i[WAYS_CFG_W-1:0];
          CFG_BLOCK_OFFSET_BITS: offset_bits = cfg_data_i[BOB_W-1:0];
          default: ;
        endcase
      end
      pending_o = result_q.size();
      fail_count_o = fails;
    end
  end

endmodule

>>> bench/tb_set_assoc_cache_lru_tracker_top.sv
// Stimulus and verdict for the LRU cache tracker, with the checker alongside.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_tracker_top;
  import salru_pkg::*;

  localparam int          RANDOM_ITEMS = 1400;
  localparam int          SETTLE_CYCLES = 6;
  localparam int          CYCLE_LIMIT = 500000;
  localparam logic [CMD_W-1:0]     CMD_SPARE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

  logic clk_i = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      command = '0;
  logic [ADDR_BITS-1:0]  address = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  first_hit;
  logic                  evicted;
  logic [CNT_W-1:0]      total_hits;
  logic [CNT_W-1:0]      total_misses;
  logic [CNT_W-1:0]      total_evictions;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int fail_count;
  int pending;
  int cycles = 0;
  bit calm = 1'b0;

  always #5 clk_i = ~clk_i;

  set_assoc_cache_lru_tracker_top uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .command_i         (command),
    .address_i         (address),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .first_hit_o       (first_hit),
    .evicted_o         (evicted),
    .total_hits_o      (total_hits),
    .total_misses_o    (total_misses),
    .total_evictions_o (total_evictions),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  salru_checker checker_i (
    .clk_i             (clk_i),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .command_i         (command),
    .address_i         (address),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .first_hit_i       (first_hit),
    .evicted_i         (evicted),
    .total_hits_i      (total_hits),
    .total_misses_i    (total_misses),
    .total_evictions_i (total_evictions),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("set_assoc_cache_lru_tracker_top: mismatch");
      $finish;
    end
  end

  function automatic int unsigned idle_draw();
    if (calm || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // Result side: random stall before each word, then take it
  initial begin
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      hold = idle_draw();
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk_i);
        out_stall = 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid) @(posedge clk_i);
      @(negedge clk_i);
    end
  end

  // One access word; called at a falling edge, returns at one
  task automatic send(input logic [CMD_W-1:0] cmd, input logic [ADDR_BITS-1:0] addr);
    int unsigned gap;
    gap = idle_draw();
    if (gap > 0) repeat (gap) @(negedge clk_i);
    in_valid = 1'b1;
    command = cmd;
    address = addr;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DATA_W'(data);
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  // Hold off until every outstanding word is back and the pipe is quiet
  task automatic settle();
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apply_setting(input int unsigned sib, input int unsigned ways,
                               input int unsigned bob);
    settle();
    write_reg(CFG_SET_INDEX_BITS, sib);
    write_reg(CFG_WAYS_IN_USE, ways);
    write_reg(CFG_BLOCK_OFFSET_BITS, bob);
  endtask

  // Address in one of a few sets with a tag from a small pool
  function automatic logic [ADDR_BITS-1:0] hot_address(int unsigned sib, int unsigned bob,
                                                        int unsigned n_ways);
    logic [63:0] wide;
    logic [63:0] set_v;
    logic [63:0] tag_v;
    set_v = 64'($urandom_range(0, 3)) & ((64'd1 << sib) - 64'd1);
    tag_v = 64'($urandom_range(0, n_ways + 2));
    wide = (tag_v << (bob + sib)) | (set_v << bob) | (64'($urandom) & ((64'd1 << bob) - 64'd1));
    return wide[ADDR_BITS-1:0];
  endfunction

  initial begin
    int unsigned sib, ways, bob, n_ways, count, mode;
    int          sent;
    int          phase;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_n = 1'b1;
    @(negedge clk_i);

    // Directed: reset setting, one way per set
    send(CMD_LOAD, 32'h0000_0000);
    send(CMD_LOAD, 32'h0000_000F);
    send(CMD_STORE, 32'hFFFF_FFFF);
    send(CMD_MODIFY, 32'h0000_0100);
    send(CMD_SPARE, 32'h0000_0100);
    send(CMD_LOAD, 32'h0000_0000);
    // Widest legal split: tag shift of 32 leaves tag zero; old lines stay
    apply_setting(8, 8, 24);
    send(CMD_LOAD, 32'hFF00_0000);
    send(CMD_STORE, 32'h00FF_FFFF);
    // Set index beyond the set count wraps; zero ways acts as one
    apply_setting(15, 0, 0);
    send(CMD_LOAD, 32'h0000_0105);
    send(CMD_LOAD, 32'h0000_0005);
    // Single set, top offset, too many ways
    apply_setting(0, 15, 31);
    send(CMD_LOAD, 32'h8000_0000);
    send(CMD_LOAD, 32'h7FFF_FFFF);
    send(CMD_MODIFY, 32'h1234_5678);
    settle();
    write_reg(CFG_SPARE_IDX, 31);
    send(CMD_LOAD, 32'hFFFF_FFFF);
    // Two-way LRU order
    apply_setting(0, 2, 0);
    send(CMD_LOAD, 32'd0);
    send(CMD_LOAD, 32'd1);
    send(CMD_LOAD, 32'd0);
    send(CMD_LOAD, 32'd2);
    send(CMD_LOAD, 32'd1);

    // Random phases, each under its own setting
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 9);
      case (mode)
        0: begin sib = 0; ways = 1; bob = 0; end
        1: begin sib = 8; ways = 8; bob = 24; end
        2: begin
          sib = $urandom_range(9, 15);
          ways = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
          bob = $urandom_range(25, 31);
        end
        default: begin
          sib = $urandom_range(0, 8);
          ways = $urandom_range(1, 8);
          bob = $urandom_range(0, 24);
        end
      endcase
      apply_setting(sib, ways, bob);
      n_ways = (ways == 0) ? 1 : ((ways > MAX_WAYS) ? MAX_WAYS : ways);
      calm = ($urandom_range(0, 3) == 0);
      count = $urandom_range(60, 160);
      for (int i = 0; i < int'(count); i++) begin
        if (i == int'(count) / 2 && (phase == 0 || $urandom_range(0, 2) == 0))
          while (pending != 0) @(negedge clk_i);
        if ($urandom_range(0, 99) < 85)
          send(CMD_W'($urandom_range(0, 3)), hot_address(sib, bob, n_ways));
        else
          send(CMD_W'($urandom_range(0, 3)), ADDR_BITS'($urandom));
      end
      sent += count;
      phase++;
    end
    calm = 1'b0;

    settle();
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("set_assoc_cache_lru_tracker_top: match");
    end else begin
      $display("set_assoc_cache_lru_tracker_top: mismatch");
    end
    $finish;
  end

endmodule
